// ===== hw/rtl/rss_pkg.sv =====
// Shared types and constants for the repeated substring scanner.
// No dependencies; compile this file first.
package rss_pkg;

    // Default sizes of the text buffer and of the report budget
    localparam int BUF_SIZE_DEF    = 4096;
    localparam int MAX_REPORTS_DEF = 63;

    // Fixed field widths of the channels
    localparam int TEXT_W   = 8;
    localparam int POS_W    = 12;
    localparam int LEN_W    = 12;
    localparam int MINLEN_W = 13;

    // Scan sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_POS,
        ST_READ,
        ST_CMP,
        ST_DECIDE,
        ST_EMIT,
        ST_END
    } t_state;

endpackage

// ===== hw/rtl/rss_if.sv =====
// Valid/ready channel interfaces of the repeated substring scanner.
// Depends on rss_pkg for the field widths.

// Text byte channel
interface rss_byte_if;
    logic                       valid;
    logic                       ready;
    logic [rss_pkg::TEXT_W-1:0] text_byte;
    logic                       is_last;

    modport source (output valid, text_byte, is_last, input ready);
    modport sink   (input valid, text_byte, is_last, output ready);
endinterface

// Match record channel
interface rss_match_if;
    logic                      valid;
    logic                      ready;
    logic [rss_pkg::POS_W-1:0] match_position;
    logic [rss_pkg::LEN_W-1:0] match_length;
    logic                      is_end;
    logic                      overflowed;

    modport source (output valid, match_position, match_length, is_end, overflowed,
                    input ready);
    modport sink   (input valid, match_position, match_length, is_end, overflowed,
                    output ready);
endinterface

// Minimum length register write channel
interface rss_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rss_pkg::MINLEN_W-1:0] min_length;

    modport source (output valid, min_length, input ready);
    modport sink   (input valid, min_length, output ready);
endinterface

// ===== hw/rtl/repeated_substring_scan.sv =====
// Top level of the repeated substring scanner: load sequencer, scan sequencer,
// output register. Depends on rss_pkg, rss_if and rss_text_ram.
//
// Usage:
//   i_byte  : text bytes, one item per cycle while loading. A zero byte ends
//             the text; later bytes of the run are ignored. Bytes past the
//             buffer size are dropped. An item with is_last set starts the scan.
//   o_match : one record per reported repeat (position, length), then an end
//             record with is_end set and overflowed set when more repeats
//             qualified than the report budget allows.
//   i_cfg   : writes the minimum reported length (zero acts as one); always
//             ready, to be written only while the block is idle.
// Scan: walks the candidate starts, skipping past each repeat found, with a
//   single shared compare unit over the two read ports of the text buffer;
//   each byte compare sets the addresses, then compares the registered reads.
//   i_byte is not ready during the scan.
// Stall: a record waits in the output register; the scan holds at the next
//   record until it is taken. Reset clears the sequencer, counters and the
//   output valid flag; the minimum length returns to one. The text buffer
//   needs no clearing.
module repeated_substring_scan #(
    parameter int BUF_SIZE    = rss_pkg::BUF_SIZE_DEF,
    parameter int MAX_REPORTS = rss_pkg::MAX_REPORTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rss_byte_if.sink      i_byte,
    rss_match_if.source   o_match,
    rss_cfg_if.sink       i_cfg
);

    localparam int AW = $clog2(BUF_SIZE);
    localparam int CW = $clog2(BUF_SIZE + 1);
    localparam int SW = CW + 1;
    localparam int RW = $clog2(MAX_REPORTS + 1);
    localparam int MW = (CW > rss_pkg::MINLEN_W) ? CW : rss_pkg::MINLEN_W;

    rss_pkg::t_state r_state, n_state;

    logic [rss_pkg::MINLEN_W-1:0] r_min_len;
    logic [CW-1:0] r_count, n_count;
    logic          r_ended, n_ended;
    logic [CW-1:0] r_len, n_len;
    logic [SW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_cp, n_cp;
    logic [CW-1:0] r_w, n_w;
    logic [CW-1:0] r_best, n_best;
    logic [RW-1:0] r_rep, n_rep;
    logic          r_over, n_over;

    logic                      r_out_valid, n_out_valid;
    logic [rss_pkg::POS_W-1:0] r_out_pos, n_out_pos;
    logic [rss_pkg::LEN_W-1:0] r_out_len, n_out_len;
    logic                      r_out_is_end, n_out_is_end;
    logic                      r_out_over, n_out_over;

    logic                       byte_acc;
    logic                       wr_en;
    logic [AW-1:0]              rd_addr_a;
    logic [AW-1:0]              rd_addr_b;
    logic [rss_pkg::TEXT_W-1:0] rd_data_a;
    logic [rss_pkg::TEXT_W-1:0] rd_data_b;
    logic [SW-1:0]              sum_a;
    logic [SW-1:0]              sum_b;
    logic                       step_ok;
    logic                       pos_ok;
    logic                       cp_ok;
    logic [CW-1:0]              best_max;
    logic [SW-1:0]              pos_skip;
    logic [rss_pkg::MINLEN_W-1:0] min_eff;
    logic                       qualifies;
    logic                       out_free;

    // Text buffer
    rss_text_ram #(.DEPTH(BUF_SIZE)) u_text_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (AW'(r_count)),
        .i_wr_data   (i_byte.text_byte),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Handshakes
    assign i_byte.ready = (r_state == rss_pkg::ST_LOAD);
    assign byte_acc     = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_match.ready;
    assign wr_en        = byte_acc && !r_ended && (i_byte.text_byte != '0) &&
                          (r_count < CW'(BUF_SIZE));

    // Shared compare unit: bounds of the next byte pair and the running best
    assign sum_a     = SW'(r_pos) + SW'(r_w);
    assign sum_b     = SW'(r_cp) + SW'(r_w);
    assign step_ok   = (sum_a < SW'(r_cp)) && (sum_b < SW'(r_len));
    assign rd_addr_a = AW'(sum_a);
    assign rd_addr_b = AW'(sum_b);
    assign pos_ok    = (r_pos + SW'(1)) < SW'(r_len);
    assign cp_ok     = r_cp < r_len;
    assign best_max  = (r_w > r_best) ? r_w : r_best;
    assign pos_skip  = r_pos + SW'(r_best) + SW'(1);
    assign min_eff   = (r_min_len == '0) ? rss_pkg::MINLEN_W'(1) : r_min_len;
    assign qualifies = (r_best > CW'(1)) && (MW'(r_best) >= MW'(min_eff));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rss_pkg::ST_LOAD: begin
                if (byte_acc && i_byte.is_last) begin
                    n_state = rss_pkg::ST_POS;
                end
            end
            rss_pkg::ST_POS: begin
                n_state = pos_ok ? rss_pkg::ST_READ : rss_pkg::ST_END;
            end
            rss_pkg::ST_READ: begin
                if (!cp_ok) begin
                    n_state = rss_pkg::ST_DECIDE;
                end else if (step_ok) begin
                    n_state = rss_pkg::ST_CMP;
                end
            end
            rss_pkg::ST_CMP: begin
                n_state = rss_pkg::ST_READ;
            end
            rss_pkg::ST_DECIDE: begin
                if (qualifies && (r_rep < RW'(MAX_REPORTS))) begin
                    n_state = rss_pkg::ST_EMIT;
                end else begin
                    n_state = rss_pkg::ST_POS;
                end
            end
            rss_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = rss_pkg::ST_POS;
                end
            end
            rss_pkg::ST_END: begin
                if (out_free) begin
                    n_state = rss_pkg::ST_LOAD;
                end
            end
            default: n_state = rss_pkg::ST_LOAD;
        endcase
    end

    // Datapath and output register updates
    always_comb begin
        n_count      = r_count;
        n_ended      = r_ended;
        n_len        = r_len;
        n_pos        = r_pos;
        n_cp         = r_cp;
        n_w          = r_w;
        n_best       = r_best;
        n_rep        = r_rep;
        n_over       = r_over;
        n_out_valid  = r_out_valid && !o_match.ready;
        n_out_pos    = r_out_pos;
        n_out_len    = r_out_len;
        n_out_is_end = r_out_is_end;
        n_out_over   = r_out_over;
        case (r_state)
            rss_pkg::ST_LOAD: begin
                if (byte_acc) begin
                    if (!r_ended && (i_byte.text_byte == '0)) begin
                        n_ended = 1'b1;
                    end
                    if (wr_en) begin
                        n_count = r_count + CW'(1);
                    end
                    // start the scan with the final length
                    if (i_byte.is_last) begin
                        n_len  = wr_en ? (r_count + CW'(1)) : r_count;
                        n_pos  = '0;
                        n_rep  = '0;
                        n_over = 1'b0;
                    end
                end
            end
            rss_pkg::ST_POS: begin
                n_cp   = CW'(r_pos + SW'(1));
                n_w    = '0;
                n_best = '0;
            end
            rss_pkg::ST_READ: begin
                // close this candidate when its bounds are hit
                if (cp_ok && !step_ok) begin
                    n_best = best_max;
                    n_cp   = r_cp + CW'(1);
                    n_w    = '0;
                end
            end
            rss_pkg::ST_CMP: begin
                if (rd_data_a == rd_data_b) begin
                    n_w = r_w + CW'(1);
                end else begin
                    n_best = best_max;
                    n_cp   = r_cp + CW'(1);
                    n_w    = '0;
                end
            end
            rss_pkg::ST_DECIDE: begin
                if (qualifies && (r_rep < RW'(MAX_REPORTS))) begin
                    n_pos = r_pos;
                end else if (r_best > CW'(1)) begin
                    if (qualifies) begin
                        n_over = 1'b1;
                    end
                    n_pos = pos_skip;
                end else begin
                    n_pos = r_pos + SW'(1);
                end
            end
            rss_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = rss_pkg::POS_W'(r_pos);
                    n_out_len    = rss_pkg::LEN_W'(r_best);
                    n_out_is_end = 1'b0;
                    n_out_over   = 1'b0;
                    n_rep        = r_rep + RW'(1);
                    n_pos        = pos_skip;
                end
            end
            rss_pkg::ST_END: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pos    = '0;
                    n_out_len    = '0;
                    n_out_is_end = 1'b1;
                    n_out_over   = r_over;
                    n_count      = '0;
                    n_ended      = 1'b0;
                    n_rep        = '0;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rss_pkg::ST_LOAD;
            r_min_len   <= rss_pkg::MINLEN_W'(1);
            r_count     <= '0;
            r_ended     <= 1'b0;
            r_rep       <= '0;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ended     <= n_ended;
            r_rep       <= n_rep;
            r_over      <= n_over;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_min_len <= i_cfg.min_length;
            end
        end
    end

    // Scan and payload registers
    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_pos        <= n_pos;
        r_cp         <= n_cp;
        r_w          <= n_w;
        r_best       <= n_best;
        r_out_pos    <= n_out_pos;
        r_out_len    <= n_out_len;
        r_out_is_end <= n_out_is_end;
        r_out_over   <= n_out_over;
    end

    assign o_match.valid          = r_out_valid;
    assign o_match.match_position = r_out_pos;
    assign o_match.match_length   = r_out_len;
    assign o_match.is_end         = r_out_is_end;
    assign o_match.overflowed     = r_out_over;

    // Checks
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte.valid && i_byte.ready && i_byte.is_last) |=> !i_byte.ready)
        else $error("byte channel ready right after the final byte");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUF_SIZE))
        else $error("text count beyond buffer size");

    a_report_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep <= RW'(MAX_REPORTS))
        else $error("report count beyond budget");

    a_end_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rss_pkg::ST_END && out_free) |=>
            (r_state == rss_pkg::ST_LOAD && r_out_is_end && r_out_valid && r_count == '0))
        else $error("end record did not return the block to loading");

endmodule

// ===== hw/rtl/rss_text_ram.sv =====
// Text buffer: one write port, two registered read ports.
// Depends on rss_pkg for the byte width.
module rss_text_ram #(
    parameter int DEPTH = rss_pkg::BUF_SIZE_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [rss_pkg::TEXT_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr_a,
    input  logic [AW-1:0]              i_rd_addr_b,
    output logic [rss_pkg::TEXT_W-1:0] o_rd_data_a,
    output logic [rss_pkg::TEXT_W-1:0] o_rd_data_b
);

    logic [rss_pkg::TEXT_W-1:0] r_mem [DEPTH];
    logic [rss_pkg::TEXT_W-1:0] r_rd_a;
    logic [rss_pkg::TEXT_W-1:0] r_rd_b;

    // Write one byte
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both ports into registers
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for repeated_substring_scan: loads texts over the byte channel,
// predicts every match and end record, and checks them in order under random stalls.
// Depends on rss_pkg, rss_if and the RTL of the block.
`timescale 1ns / 100ps

module testbench;

    // Buffer and report budget at their default sizes
    localparam int TEXT_DEPTH    = rss_pkg::BUF_SIZE_DEF;
    localparam int REPORT_LIMIT  = rss_pkg::MAX_REPORTS_DEF;
    localparam int RANDOM_ITEMS  = 32;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 1000000;

    typedef struct packed {
        logic [rss_pkg::POS_W-1:0] rep_pos;
        logic [rss_pkg::LEN_W-1:0] rep_len;
        logic                      is_end;
        logic                      overflowed;
    } t_match_rec;

    logic clk;
    logic rst_n;

    rss_byte_if  byte_ch ();
    rss_match_if match_ch ();
    rss_cfg_if   cfg_ch ();

    repeated_substring_scan #(
        .BUF_SIZE    (TEXT_DEPTH),
        .MAX_REPORTS (REPORT_LIMIT)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_match (match_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: loaded text, end-of-text flag and minimum length
    logic [7:0]                   text_mem [TEXT_DEPTH];
    int unsigned                  text_len;
    logic                         text_closed;
    logic [rss_pkg::MINLEN_W-1:0] min_len_cfg;
    t_match_rec                   expected_records[$];

    // Run control and statistics
    logic        sender_gaps;
    logic        sink_stalls;
    int unsigned hold_requests;
    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned scans_done;
    int unsigned match_records;
    int unsigned end_records;
    int unsigned overflow_scans;
    int unsigned quiet_cycles;

    // Generate the clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Longest later non-overlapping copy of the text starting at p
    function automatic int unsigned longest_later_copy(int unsigned p, int unsigned n);
        int unsigned best;
        int unsigned cp;
        int unsigned w;
        best = 0;
        for (cp = p + 1; cp < n; cp++) begin
            if (text_mem[p] == text_mem[cp]) begin
                w = 1;
                while (p + w < cp && cp + w < n && text_mem[p + w] == text_mem[cp + w])
                    w++;
                if (w > best)
                    best = w;
            end
        end
        return best;
    endfunction

    // Scan the loaded text and queue its match records and end record
    task automatic scan_loaded_text();
        int unsigned n;
        int unsigned p;
        int unsigned best;
        int unsigned minl;
        int unsigned reported;
        logic        over;
        t_match_rec  rec;
        n = text_len;
        minl = (min_len_cfg == '0) ? 1 : min_len_cfg;
        reported = 0;
        over = 1'b0;
        for (p = 0; p + 1 < n; p++) begin
            best = longest_later_copy(p, n);
            if (best > 1) begin
                if (best >= minl) begin
                    if (reported < REPORT_LIMIT) begin
                        rec.rep_pos = rss_pkg::POS_W'(p);
                        rec.rep_len = rss_pkg::LEN_W'(best);
                        rec.is_end = 1'b0;
                        rec.overflowed = 1'b0;
                        expected_records.push_back(rec);
                        reported++;
                    end else begin
                        over = 1'b1;
                    end
                end
                // Skip over the repeat and the position after it
                p += best;
            end
        end
        rec.rep_pos = '0;
        rec.rep_len = '0;
        rec.is_end = 1'b1;
        rec.overflowed = over;
        expected_records.push_back(rec);
        if (over)
            overflow_scans++;
        scans_done++;
        text_len = 0;
        text_closed = 1'b0;
    endtask

    // Load one accepted byte; a last byte starts the scan
    task automatic predict_byte(input logic [7:0] b, input logic last);
        if (!text_closed) begin
            if (b == 8'h00)
                text_closed = 1'b1;
            else if (text_len < TEXT_DEPTH) begin
                text_mem[text_len] = b;
                text_len++;
            end
        end
        if (last)
            scan_loaded_text();
    endtask

    // Offer one byte item, with an optional gap first, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.text_byte <= b;
        byte_ch.is_last <= last;
        do @(posedge clk); while (byte_ch.ready !== 1'b1);
        bytes_sent++;
        predict_byte(b, last);
    endtask

    // Send a whole text; the final byte carries the last flag
    task automatic send_text(input logic [7:0] txt[$]);
        int unsigned i;
        for (i = 0; i < txt.size(); i++)
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    // Drop valid, drain all expected records, then let the block settle
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_records.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the minimum length register while the block is idle
    task automatic write_min_length(input logic [rss_pkg::MINLEN_W-1:0] v);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.min_length <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        min_len_cfg = v;
    endtask

    // Text "a b s1 a b s2 ... a b sk a b": one length-two repeat per group of three
    task automatic send_pair_chain(input int unsigned groups);
        logic [7:0]  txt[$];
        logic [7:0]  seps[$];
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  tmp;
        int unsigned i;
        int unsigned j;
        a = 8'($urandom_range(1, 255));
        do b = 8'($urandom_range(1, 255)); while (b == a);
        for (i = 1; i < 256; i++)
            if (8'(i) != a && 8'(i) != b)
                seps.push_back(8'(i));
        // Shuffle the separators
        for (i = seps.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = seps[i];
            seps[i] = seps[j];
            seps[j] = tmp;
        end
        for (i = 0; i < groups; i++) begin
            txt.push_back(a);
            txt.push_back(b);
            txt.push_back(seps[i]);
        end
        txt.push_back(a);
        txt.push_back(b);
        send_text(txt);
    endtask

    // Random text: mostly small alphabets that repeat, some noise, some tiny texts
    task automatic send_random_text(inout int unsigned sent);
        logic [7:0]  txt[$];
        logic [7:0]  alphabet[4];
        int unsigned shape;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        shape = $urandom_range(0, 9);
        if (shape < 7) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48) : $urandom_range(2, 20);
            k = $urandom_range(2, 4);
            for (i = 0; i < 4; i++)
                alphabet[i] = 8'($urandom_range(1, 255));
            for (i = 0; i < n; i++)
                txt.push_back(alphabet[$urandom_range(0, k - 1)]);
            // Sometimes end the text early with a zero byte
            if ($urandom_range(0, 6) == 0)
                txt[$urandom_range(0, n - 1)] = 8'h00;
        end else if (shape < 9) begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            txt.push_back(8'($urandom_range(0, 255)));
        end
        send_text(txt);
        sent += txt.size();
    endtask

    // Empty text, one-byte text, and repeats of length one and two
    task automatic test_short_texts();
        logic [7:0] txt[$];
        txt = '{8'h00};
        send_text(txt);
        txt = '{8'hFF};
        send_text(txt);
        txt = '{8'h01, 8'h80, 8'h01};
        send_text(txt);
        txt = '{8'h7F, 8'hFF, 8'h7F, 8'hFF};
        send_text(txt);
        wait_idle();
    endtask

    // Bytes after a zero byte are ignored up to the last byte
    task automatic test_zero_ends_text();
        logic [7:0] txt[$];
        txt = '{8'h51, 8'h52, 8'h51, 8'h52, 8'h00, 8'h51};
        send_text(txt);
        wait_idle();
    endtask

    // Minimum length of zero, above the repeat, and at the top of the register
    task automatic test_min_length();
        logic [7:0] txt[$];
        txt = '{8'h61, 8'h62, 8'h61, 8'h62};
        write_min_length('0);
        send_text(txt);
        write_min_length(rss_pkg::MINLEN_W'(3));
        send_text(txt);
        write_min_length('1);
        send_text(txt);
        wait_idle();
    endtask

    // One repeat more than the report budget; then hold the record side off for a
    // long stretch while the next text waits at the input
    task automatic test_report_budget();
        write_min_length(rss_pkg::MINLEN_W'(1));
        send_pair_chain(REPORT_LIMIT + 1);
        hold_requests++;
        send_pair_chain(1);
        wait_idle();
    endtask

    // Random texts in phases with different minimum lengths; the last phase has no gaps or stalls
    task automatic test_random_texts();
        logic [rss_pkg::MINLEN_W-1:0] phase_min[4];
        int unsigned                  phase;
        int unsigned                  target;
        int unsigned                  sent;
        phase_min[0] = rss_pkg::MINLEN_W'(2);
        phase_min[1] = rss_pkg::MINLEN_W'(4096);
        phase_min[2] = rss_pkg::MINLEN_W'($urandom_range(1, 4));
        phase_min[3] = rss_pkg::MINLEN_W'(1);
        sent = 0;
        for (phase = 0; phase < 4; phase++) begin
            write_min_length(phase_min[phase]);
            if (phase == 3) begin
                sender_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            target = RANDOM_ITEMS * (phase + 1) / 4;
            while (sent < target)
                send_random_text(sent);
        end
        wait_idle();
    endtask

    // Compare one taken record with the oldest expectation
    task automatic check_record();
        t_match_rec want;
        if (expected_records.size() == 0) begin
            $error("record with nothing expected: position %0d length %0d end %0b",
                   match_ch.match_position, match_ch.match_length, match_ch.is_end);
            error_count++;
        end else begin
            want = expected_records.pop_front();
            if (match_ch.match_position !== want.rep_pos) begin
                $error("match_position: expected %0d, got %0d", want.rep_pos,
                       match_ch.match_position);
                error_count++;
            end
            if (match_ch.match_length !== want.rep_len) begin
                $error("match_length: expected %0d, got %0d", want.rep_len,
                       match_ch.match_length);
                error_count++;
            end
            if (match_ch.is_end !== want.is_end) begin
                $error("is_end: expected %0b, got %0b", want.is_end, match_ch.is_end);
                error_count++;
            end
            if (match_ch.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, got %0b", want.overflowed,
                       match_ch.overflowed);
                error_count++;
            end
            if (want.is_end)
                end_records++;
            else
                match_records++;
        end
    endtask

    // Take records; stall in short bursts, or for a long stretch on request
    initial begin : record_sink
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned holds_seen;
        hold_left = 0;
        stall_left = 0;
        holds_seen = 0;
        match_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (match_ch.valid === 1'b1 && match_ch.ready === 1'b1)
                check_record();
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                match_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                match_ch.ready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                match_ch.ready <= 1'b0;
            end else begin
                match_ch.ready <= 1'b1;
            end
        end
    end

    // End the run when nothing has been taken for too long
    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
            (match_ch.valid === 1'b1 && match_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: timeout after %0d quiet cycles", quiet_cycles);
            $display("testbench: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Reset, run each test in turn, then report
    initial begin : run_tests
        text_len = 0;
        text_closed = 1'b0;
        min_len_cfg = rss_pkg::MINLEN_W'(1);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        hold_requests = 0;
        error_count = 0;
        bytes_sent = 0;
        scans_done = 0;
        match_records = 0;
        end_records = 0;
        overflow_scans = 0;
        rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.text_byte <= '0;
        byte_ch.is_last <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.min_length <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_texts();
        test_zero_ends_text();
        test_min_length();
        test_report_budget();
        test_random_texts();

        $display("summary: %0d text bytes in %0d scans, %0d with overflow",
                 bytes_sent, scans_done, overflow_scans);
        $display("summary: %0d match records and %0d end records checked, %0d errors",
                 match_records, end_records, error_count);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
